### src/ucep_pkg.sv
// Shared types and constants for the USB endpoint-zero control transfer sequencer.
// Holds the request and result structs, the classified command, and the stage encoding.
// No dependencies.
package ucep_pkg;

    // Event kinds carried by each input request
    typedef enum logic [1:0] {
        KIND_SETUP = 2'd0,
        KIND_OUT   = 2'd1,
        KIND_IN    = 2'd2,
        KIND_RESET = 2'd3
    } t_kind;

    // Control stages, one-hot
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIN  = 7'b0000010,
        ST_LIN  = 7'b0000100,
        ST_SIN  = 7'b0001000,
        ST_DOUT = 7'b0010000,
        ST_LOUT = 7'b0100000,
        ST_SOUT = 7'b1000000
    } t_stage;

    // Stage codes as reported on the result
    localparam logic [2:0] STG_CODE_IDLE = 3'd0;
    localparam logic [2:0] STG_CODE_DIN  = 3'd2;
    localparam logic [2:0] STG_CODE_LIN  = 3'd3;
    localparam logic [2:0] STG_CODE_SIN  = 3'd4;
    localparam logic [2:0] STG_CODE_DOUT = 3'd5;
    localparam logic [2:0] STG_CODE_LOUT = 3'd6;
    localparam logic [2:0] STG_CODE_SOUT = 3'd7;

    // Standard request fields
    localparam logic [7:0] REQ_SET_ADDRESS  = 8'd5;
    localparam logic [7:0] REQ_TYPE_STD_OUT = 8'h00;
    localparam int         DIR_IN_BIT       = 7;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
        logic        setup_ok;
        logic [9:0]  out_count;
        logic        handler_ok;
        logic [15:0] reply_length;
    } t_in_item;

    typedef struct packed {
        logic       send_data;
        logic       accept_data;
        logic [9:0] buffer_offset;
        logic [6:0] packet_length;
        logic       stall_res;
        logic       handler_called;
        logic       transfer_done;
        logic       set_address;
        logic [6:0] device_address;
        logic       rx_ready;
        logic [2:0] stage;
    } t_out_item;

    // Classified request handed from front to back
    typedef struct packed {
        t_kind       kind;
        logic        setup_ok;
        logic        handler_ok;
        logic        dir_in;       // read request or no data stage
        logic        long_write;   // write longer than the buffer
        logic        long_out;     // write needs more than one packet
        logic [7:0]  req_type;
        logic [7:0]  req_code;
        logic [6:0]  req_addr;
        logic [15:0] req_length;
        logic [10:0] reply_sat;    // reply clipped to buffer and wLength
        logic        short_reply;  // clipped reply shorter than wLength
        logic [9:0]  out_count;
    } t_cmd;

    function automatic logic [2:0] stage_code(input t_stage s);
        logic [2:0] c;
        case (s)
            ST_IDLE: c = STG_CODE_IDLE;
            ST_DIN:  c = STG_CODE_DIN;
            ST_LIN:  c = STG_CODE_LIN;
            ST_SIN:  c = STG_CODE_SIN;
            ST_DOUT: c = STG_CODE_DOUT;
            ST_LOUT: c = STG_CODE_LOUT;
            ST_SOUT: c = STG_CODE_SOUT;
            default: c = STG_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

### src/ucep_front.sv
// Front end: classifies each incoming request before it is queued.
// Clips the reply length and flags direction and size cases. Uses ucep_pkg.
module ucep_front #(
    parameter int MAX_PACKET   = 64,
    parameter int BUFFER_BYTES = 1024
) (
    input  ucep_pkg::t_in_item i_item,
    output ucep_pkg::t_cmd     o_cmd
);
    import ucep_pkg::*;

    localparam logic [15:0] BUF_LEN = 16'(BUFFER_BYTES);
    localparam logic [15:0] MAX_LEN = 16'(MAX_PACKET);

    logic [15:0] reply_buf;
    logic [15:0] reply_cut;

    // Clip the reply to the buffer, then to wLength
    always_comb begin
        reply_buf = (i_item.reply_length > BUF_LEN) ? BUF_LEN : i_item.reply_length;
        reply_cut = (reply_buf > i_item.request_length) ? i_item.request_length : reply_buf;
    end

    // Build the classified request
    always_comb begin
        o_cmd.kind        = i_item.kind;
        o_cmd.setup_ok    = i_item.setup_ok;
        o_cmd.handler_ok  = i_item.handler_ok;
        o_cmd.dir_in      = (i_item.request_length == 16'd0)
                            || i_item.request_type[DIR_IN_BIT];
        o_cmd.long_write  = i_item.request_length > BUF_LEN;
        o_cmd.long_out    = i_item.request_length > MAX_LEN;
        o_cmd.req_type    = i_item.request_type;
        o_cmd.req_code    = i_item.request_code;
        o_cmd.req_addr    = i_item.request_value[6:0];
        o_cmd.req_length  = i_item.request_length;
        o_cmd.reply_sat   = reply_cut[10:0];
        o_cmd.short_reply = reply_cut < i_item.request_length;
        o_cmd.out_count   = i_item.out_count;
    end

endmodule

### src/ucep_queue.sv
// Short queue of classified requests between front and back.
// Register-based, one push and one pop per cycle; a push is ignored while the queue is full. Uses ucep_pkg.
module ucep_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ucep_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ucep_pkg::t_cmd  o_data
);
    import ucep_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### src/ucep_back.sv
// Back end: runs the control stage machine on each classified request.
// Holds transfer state and the output register. Uses ucep_pkg.
module ucep_back #(
    parameter int MAX_PACKET   = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  ucep_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output ucep_pkg::t_out_item o_result
);
    import ucep_pkg::*;

    localparam logic [6:0]  MAX_LEN7  = 7'(MAX_PACKET);
    localparam logic [10:0] MAX_LEN11 = 11'(MAX_PACKET);
    localparam logic [15:0] MAX_LEN16 = 16'(MAX_PACKET);

    t_stage      r_stage,      n_stage;
    logic [10:0] r_bytes_left, n_bytes_left;
    logic [10:0] r_send_off,   n_send_off;
    logic        r_zlp,        n_zlp;
    logic [7:0]  r_saved_type, n_saved_type;
    logic [7:0]  r_saved_code, n_saved_code;
    logic [6:0]  r_saved_addr, n_saved_addr;
    logic [15:0] r_saved_len,  n_saved_len;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   res;

    // Chunk step inputs and outputs
    logic        from_setup;
    logic [10:0] c_bl;
    logic [10:0] c_off;
    logic        c_zlp;
    logic        c_big;
    logic [6:0]  c_len;
    t_stage      c_stage;
    logic [10:0] c_bl_next;
    logic [10:0] c_off_next;
    logic        c_zlp_next;

    // OUT data step
    logic [15:0] o_rem;
    logic [6:0]  o_pkt;
    logic [10:0] o_bl_next;
    logic [15:0] o_rem2;
    logic        o_short;

    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // Next IN chunk, started either from a setup or from the saved state
    always_comb begin
        from_setup = (i_cmd.kind == KIND_SETUP);
        c_bl       = from_setup ? i_cmd.reply_sat   : r_bytes_left;
        c_off      = from_setup ? 11'd0             : r_send_off;
        c_zlp      = from_setup ? i_cmd.short_reply : r_zlp;
        c_big      = c_bl > MAX_LEN11;
        if (c_big) begin
            c_len      = MAX_LEN7;
            c_stage    = ST_DIN;
            c_off_next = c_off + MAX_LEN11;
            c_bl_next  = c_bl - MAX_LEN11;
            c_zlp_next = c_zlp;
        end else begin
            c_len      = c_bl[6:0];
            // a full final chunk of a short reply needs a trailing empty packet
            c_stage    = (c_zlp && (c_bl == MAX_LEN11)) ? ST_DIN : ST_LIN;
            c_off_next = c_off;
            c_bl_next  = 11'd0;
            c_zlp_next = 1'b0;
        end
    end

    // Expected OUT packet size and progress
    always_comb begin
        o_rem     = ({5'd0, r_bytes_left} < r_saved_len)
                    ? r_saved_len - {5'd0, r_bytes_left} : 16'd0;
        o_pkt     = (o_rem < MAX_LEN16) ? o_rem[6:0] : MAX_LEN7;
        o_short   = {3'd0, o_pkt} > i_cmd.out_count;
        o_bl_next = r_bytes_left + {4'd0, o_pkt};
        o_rem2    = ({5'd0, o_bl_next} < r_saved_len)
                    ? r_saved_len - {5'd0, o_bl_next} : 16'd0;
    end

    // Stage machine and result
    always_comb begin
        n_stage      = r_stage;
        n_bytes_left = r_bytes_left;
        n_send_off   = r_send_off;
        n_zlp        = r_zlp;
        n_saved_type = r_saved_type;
        n_saved_code = r_saved_code;
        n_saved_addr = r_saved_addr;
        n_saved_len  = r_saved_len;
        res          = '0;
        case (i_cmd.kind)
            KIND_SETUP: begin
                if (!i_cmd.setup_ok) begin
                    res.stall_res = 1'b1;
                    n_stage       = ST_IDLE;
                end else begin
                    n_saved_type = i_cmd.req_type;
                    n_saved_code = i_cmd.req_code;
                    n_saved_addr = i_cmd.req_addr;
                    n_saved_len  = i_cmd.req_length;
                    if (i_cmd.dir_in) begin
                        n_send_off         = 11'd0;
                        res.handler_called = 1'b1;
                        if (!i_cmd.handler_ok) begin
                            res.stall_res = 1'b1;
                            n_stage       = ST_IDLE;
                        end else if (i_cmd.req_length != 16'd0) begin
                            res.send_data     = 1'b1;
                            res.buffer_offset = 10'd0;
                            res.packet_length = c_len;
                            n_stage           = c_stage;
                            n_send_off        = c_off_next;
                            n_bytes_left      = c_bl_next;
                            n_zlp             = c_zlp_next;
                        end else begin
                            res.send_data = 1'b1;
                            n_stage       = ST_SIN;
                        end
                    end else if (i_cmd.long_write) begin
                        res.stall_res = 1'b1;
                        n_stage       = ST_IDLE;
                    end else begin
                        n_bytes_left = 11'd0;
                        n_stage      = i_cmd.long_out ? ST_DOUT : ST_LOUT;
                        res.rx_ready = 1'b1;
                    end
                end
            end
            KIND_OUT: begin
                if (r_stage == ST_DOUT || r_stage == ST_LOUT) begin
                    if (o_short) begin
                        res.stall_res = 1'b1;
                        n_stage       = ST_IDLE;
                    end else begin
                        n_bytes_left = o_bl_next;
                        if (r_stage == ST_DOUT) begin
                            res.accept_data   = 1'b1;
                            res.buffer_offset = r_bytes_left[9:0];
                            res.packet_length = o_pkt;
                            res.rx_ready      = 1'b1;
                            if (o_rem2 <= MAX_LEN16) begin
                                n_stage = ST_LOUT;
                            end
                        end else begin
                            res.handler_called = 1'b1;
                            if (i_cmd.handler_ok) begin
                                res.accept_data   = 1'b1;
                                res.buffer_offset = r_bytes_left[9:0];
                                res.packet_length = o_pkt;
                                res.rx_ready      = 1'b1;
                                res.send_data     = 1'b1;
                                n_stage           = ST_SIN;
                            end else begin
                                res.stall_res = 1'b1;
                                n_stage       = ST_IDLE;
                            end
                        end
                    end
                end else if (r_stage == ST_SOUT) begin
                    res.transfer_done = 1'b1;
                    res.rx_ready      = 1'b1;
                    n_stage           = ST_IDLE;
                end else begin
                    res.stall_res = 1'b1;
                    n_stage       = ST_IDLE;
                end
            end
            KIND_IN: begin
                case (r_stage)
                    ST_DIN: begin
                        res.send_data     = 1'b1;
                        res.buffer_offset = r_send_off[9:0];
                        res.packet_length = c_len;
                        n_stage           = c_stage;
                        n_send_off        = c_off_next;
                        n_bytes_left      = c_bl_next;
                        n_zlp             = c_zlp_next;
                    end
                    ST_LIN: begin
                        res.rx_ready = 1'b1;
                        n_stage      = ST_SOUT;
                    end
                    ST_SIN: begin
                        res.transfer_done = 1'b1;
                        if (r_saved_type == REQ_TYPE_STD_OUT
                                && r_saved_code == REQ_SET_ADDRESS) begin
                            res.set_address    = 1'b1;
                            res.device_address = r_saved_addr;
                        end
                        n_stage = ST_IDLE;
                    end
                    default: begin
                        res.stall_res = 1'b1;
                        n_stage       = ST_IDLE;
                    end
                endcase
            end
            KIND_RESET: begin
                n_stage        = ST_IDLE;
                n_bytes_left   = 11'd0;
                n_send_off     = 11'd0;
                n_zlp          = 1'b0;
                n_saved_type   = 8'd0;
                n_saved_code   = 8'd0;
                n_saved_addr   = 7'd0;
                n_saved_len    = 16'd0;
                res.set_address = 1'b1;
                res.rx_ready    = 1'b1;
            end
            default: begin
                n_stage = r_stage;
            end
        endcase
        res.stage = stage_code(n_stage);
    end

    // Update transfer state on each executed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ST_IDLE;
            r_bytes_left <= 11'd0;
            r_send_off   <= 11'd0;
            r_zlp        <= 1'b0;
            r_saved_type <= 8'd0;
            r_saved_code <= 8'd0;
            r_saved_addr <= 7'd0;
            r_saved_len  <= 16'd0;
        end else if (o_cmd_pop) begin
            r_stage      <= n_stage;
            r_bytes_left <= n_bytes_left;
            r_send_off   <= n_send_off;
            r_zlp        <= n_zlp;
            r_saved_type <= n_saved_type;
            r_saved_code <= n_saved_code;
            r_saved_addr <= n_saved_addr;
            r_saved_len  <= n_saved_len;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out <= res;
        end
    end

endmodule

### src/usb_control_endpoint_fsm_top.sv
// Top level of the USB endpoint-zero control transfer sequencer.
// Connects front classifier, request queue and back stage machine. Uses ucep_pkg.
//
//   channel  valid         stall         payload
//   input    i_in_valid    o_in_stall    i_in_item    (t_in_item)
//   output   o_out_valid   i_out_stall   o_out_result (t_out_item)
//
// One request per cycle sustained while the output is not stalled; each request yields exactly one result.
// A request passes through the queue stage, then the stage machine and result register.
// The stage machine executes one request per cycle whenever the result register is free or being taken.
// A stalled output fills the two-entry queue before o_in_stall rises.
// Synchronous active-low reset empties the queue and returns the stage to idle.
module usb_control_endpoint_fsm_top #(
    parameter int MAX_PACKET   = 64,
    parameter int BUFFER_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ucep_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ucep_pkg::t_out_item o_out_result
);
    import ucep_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign o_in_stall = q_full;

    ucep_front #(
        .MAX_PACKET   (MAX_PACKET),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    ucep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_cmd)
    );

    ucep_back #(
        .MAX_PACKET   (MAX_PACKET)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_result    (o_out_result)
    );

endmodule
